>>> rtl/rqrm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rqrm_pkg
// Shared types, widths and fixed-point helpers of the relative quaternion core.
// ----------------------------------------------------------------------------
package rqrm_pkg;

  localparam int FRAC_BITS = 14;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int TWO       = 2 * ONE;
  localparam int OUT_MAX   = (ONE < 32767) ? ONE : 32767;
  localparam int OUT_MIN   = (-ONE > -32768) ? -ONE : -32768;

  localparam int CW    = 16;
  localparam int EW    = FRAC_BITS + 4;
  localparam int T_W   = FRAC_BITS + 3;
  localparam int RAD_W = T_W + FRAC_BITS + ((T_W + FRAC_BITS) % 2);
  localparam int RT_W  = RAD_W / 2;
  localparam int NUM_W = 2 * FRAC_BITS;
  localparam int PW    = 48;

  localparam logic [PW-1:0] RND_HALF = PW'(1) << (FRAC_BITS - 1);

  typedef logic signed [CW-1:0] comp_t;
  typedef logic signed [EW-1:0] elem_t;

  typedef enum logic [1:0] {
    BIG_W = 2'd0,
    BIG_X = 2'd1,
    BIG_Y = 2'd2,
    BIG_Z = 2'd3
  } big_e;

  typedef struct packed {
    big_e  big;
    elem_t d0;
    elem_t d1;
    elem_t d2;
  } side_t;

  function automatic logic signed [PW-1:0] rnd_sh(input logic signed [PW-1:0] v);
    logic [PW-1:0] mag;
    logic [PW-1:0] r;
    mag = v[PW-1] ? PW'(-v) : PW'(v);
    r   = (mag + RND_HALF) >> FRAC_BITS;
    return v[PW-1] ? -$signed(r) : $signed(r);
  endfunction

  function automatic elem_t clamp2(input logic signed [PW-1:0] v);
    if (v > PW'(TWO)) begin
      return EW'(TWO);
    end else if (v < -PW'(TWO)) begin
      return EW'(-TWO);
    end
    return EW'(v);
  endfunction

  function automatic comp_t sat_out(input logic signed [PW-1:0] v);
    if (v > PW'(OUT_MAX)) begin
      return CW'(OUT_MAX);
    end else if (v < PW'(OUT_MIN)) begin
      return CW'(OUT_MIN);
    end
    return CW'(v);
  endfunction

endpackage
`default_nettype wire

>>> rtl/rqrm_quat_mat.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rqrm_quat_mat
// Two-stage rotation matrix of one quaternion: products, then round and clamp.
// ----------------------------------------------------------------------------
module rqrm_quat_mat import rqrm_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  vld_i,
  input  comp_t w_i,
  input  comp_t x_i,
  input  comp_t y_i,
  input  comp_t z_i,
  output logic  vld_o,
  output elem_t m_o [9]
);

  logic [1:0] vld_q;
  logic signed [31:0] xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;
  elem_t m_d [9];
  elem_t m_q [9];

  function automatic logic signed [PW-1:0] dbl(input logic signed [31:0] a,
                                                input logic signed [31:0] b,
                                                input logic sub);
    logic signed [PW-1:0] s;
    s = sub ? (PW'(a) - PW'(b)) : (PW'(a) + PW'(b));
    return rnd_sh(s <<< 1);
  endfunction

  always_comb begin
    m_d[0] = clamp2(PW'(ONE) - dbl(yy_q, zz_q, 1'b0));
    m_d[1] = clamp2(dbl(xy_q, wz_q, 1'b1));
    m_d[2] = clamp2(dbl(xz_q, wy_q, 1'b0));
    m_d[3] = clamp2(dbl(xy_q, wz_q, 1'b0));
    m_d[4] = clamp2(PW'(ONE) - dbl(xx_q, zz_q, 1'b0));
    m_d[5] = clamp2(dbl(yz_q, wx_q, 1'b1));
    m_d[6] = clamp2(dbl(xz_q, wy_q, 1'b1));
    m_d[7] = clamp2(dbl(yz_q, wx_q, 1'b0));
    m_d[8] = clamp2(PW'(ONE) - dbl(xx_q, yy_q, 1'b0));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xx_q <= x_i * x_i;
      yy_q <= y_i * y_i;
      zz_q <= z_i * z_i;
      xy_q <= x_i * y_i;
      xz_q <= x_i * z_i;
      yz_q <= y_i * z_i;
      wx_q <= w_i * x_i;
      wy_q <= w_i * y_i;
      wz_q <= w_i * z_i;
      m_q  <= m_d;
    end
  end

  assign vld_o = vld_q[1];
  assign m_o   = m_q;

endmodule
`default_nettype wire

>>> rtl/rqrm_mat_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rqrm_mat_mul
// Two-stage product of transposed A with B: 27 products, then round and sum.
// ----------------------------------------------------------------------------
module rqrm_mat_mul import rqrm_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  vld_i,
  input  elem_t ma_i [9],
  input  elem_t mb_i [9],
  output logic  vld_o,
  output elem_t r_o [9]
);

  logic [1:0] vld_q;
  logic signed [31:0] p_d [27];
  logic signed [31:0] p_q [27];
  elem_t r_d [9];
  elem_t r_q [9];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          p_d[i*9 + j*3 + k] = ma_i[3*k + i] * mb_i[3*k + j];
        end
      end
    end
  end

  always_comb begin
    for (int n = 0; n < 9; n++) begin
      r_d[n] = clamp2(rnd_sh(PW'(p_q[3*n])) + rnd_sh(PW'(p_q[3*n + 1]))
                      + rnd_sh(PW'(p_q[3*n + 2])));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
      r_q <= r_d;
    end
  end

  assign vld_o = vld_q[1];
  assign r_o   = r_q;

endmodule
`default_nettype wire

>>> rtl/rqrm_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rqrm_sqrt
// Pipelined digit-by-digit integer square root of t shifted by FRAC_BITS.
// ----------------------------------------------------------------------------
module rqrm_sqrt import rqrm_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  logic [T_W-1:0]  t_i,
  input  side_t           side_i,
  output logic            vld_o,
  output logic [RT_W-1:0] root_o,
  output side_t           side_o
);

  localparam int SQ_STAGES = 4;
  localparam int SQ_STEP   = RT_W / SQ_STAGES;
  localparam int REM_W     = RT_W + 3;

  typedef struct packed {
    logic [RAD_W-1:0] rad;
    logic [REM_W-1:0] rem;
    logic [RT_W-1:0]  root;
  } sq_t;

  function automatic sq_t sq_run(input sq_t s);
    sq_t r;
    logic [REM_W-1:0] trial;
    r = s;
    for (int i = 0; i < SQ_STEP; i++) begin
      r.rem = {r.rem[REM_W-3:0], r.rad[RAD_W-1 -: 2]};
      r.rad = r.rad << 2;
      trial = REM_W'({r.root, 2'b01});
      if (r.rem >= trial) begin
        r.rem  = r.rem - trial;
        r.root = {r.root[RT_W-2:0], 1'b1};
      end else begin
        r.root = {r.root[RT_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  logic [SQ_STAGES-1:0] vld_q;
  sq_t   st_d [SQ_STAGES];
  sq_t   st_q [SQ_STAGES];
  side_t sd_q [SQ_STAGES];
  sq_t   init;

  always_comb begin
    init.rad  = RAD_W'({t_i, {FRAC_BITS{1'b0}}});
    init.rem  = '0;
    init.root = '0;
    st_d[0]   = sq_run(init);
    for (int s = 1; s < SQ_STAGES; s++) begin
      st_d[s] = sq_run(st_q[s-1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[SQ_STAGES-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q    <= st_d;
      sd_q[0] <= side_i;
      for (int s = 1; s < SQ_STAGES; s++) begin
        sd_q[s] <= sd_q[s-1];
      end
    end
  end

  assign vld_o  = vld_q[SQ_STAGES-1];
  assign root_o = st_q[SQ_STAGES-1].root;
  assign side_o = sd_q[SQ_STAGES-1];

endmodule
`default_nettype wire

>>> rtl/rqrm_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rqrm_div
// Pipelined restoring division for the rounded reciprocal of the root.
// ----------------------------------------------------------------------------
module rqrm_div import rqrm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  logic [RT_W-1:0]  den_i,
  input  side_t            side_i,
  output logic             vld_o,
  output logic [NUM_W-1:0] quo_o,
  output logic [RT_W-1:0]  den_o,
  output side_t            side_o
);

  localparam int DV_STAGES = 7;
  localparam int DV_STEP   = NUM_W / DV_STAGES;
  localparam logic [NUM_W-1:0] RECIP_NUM = NUM_W'(1) << (NUM_W - 1);

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [RT_W:0]    rem;
    logic [NUM_W-1:0] quo;
  } dv_t;

  function automatic dv_t dv_run(input dv_t s, input logic [RT_W-1:0] den);
    dv_t r;
    logic [RT_W:0] rem2;
    r = s;
    for (int i = 0; i < DV_STEP; i++) begin
      rem2  = {r.rem[RT_W-1:0], r.num[NUM_W-1]};
      r.num = r.num << 1;
      if (rem2 >= {1'b0, den}) begin
        r.rem = rem2 - {1'b0, den};
        r.quo = {r.quo[NUM_W-2:0], 1'b1};
      end else begin
        r.rem = rem2;
        r.quo = {r.quo[NUM_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  logic [DV_STAGES-1:0] vld_q;
  dv_t              st_d  [DV_STAGES];
  dv_t              st_q  [DV_STAGES];
  logic [RT_W-1:0]  den_q [DV_STAGES];
  side_t            sd_q  [DV_STAGES];
  dv_t              init;

  always_comb begin
    init.num = RECIP_NUM + NUM_W'(den_i >> 1);
    init.rem = '0;
    init.quo = '0;
    st_d[0]  = dv_run(init, den_i);
    for (int s = 1; s < DV_STAGES; s++) begin
      st_d[s] = dv_run(st_q[s-1], den_q[s-1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[DV_STAGES-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q     <= st_d;
      den_q[0] <= den_i;
      sd_q[0]  <= side_i;
      for (int s = 1; s < DV_STAGES; s++) begin
        den_q[s] <= den_q[s-1];
        sd_q[s]  <= sd_q[s-1];
      end
    end
  end

  assign vld_o  = vld_q[DV_STAGES-1];
  assign quo_o  = st_q[DV_STAGES-1].quo;
  assign den_o  = den_q[DV_STAGES-1];
  assign side_o = sd_q[DV_STAGES-1];

endmodule
`default_nettype wire

>>> rtl/relative_quaternion_via_rotation_matrix_core.sv
// Throughput: one request per cycle; the whole pipeline advances together and
// holds while a result waits under stall.
// Depth is mostly the 4-stage square root and the 7-stage reciprocal divider.
// Reset clears only the valid bits; no clearing pass.
`default_nettype none
// ----------------------------------------------------------------------------
// relative_quaternion_via_rotation_matrix_core
// Relative rotation A^T*B of two quaternions, converted back by Shepperd.
// ----------------------------------------------------------------------------
module relative_quaternion_via_rotation_matrix_core import rqrm_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  stall_o,
  input  comp_t a_w_i,
  input  comp_t a_x_i,
  input  comp_t a_y_i,
  input  comp_t a_z_i,
  input  comp_t b_w_i,
  input  comp_t b_x_i,
  input  comp_t b_y_i,
  input  comp_t b_z_i,
  output logic  valid_o,
  input  logic  stall_i,
  output comp_t rel_w_o,
  output comp_t rel_x_o,
  output comp_t rel_y_o,
  output comp_t rel_z_o
);

  logic en;
  logic ma_vld, mb_vld, r_vld, sq_vld, dv_vld;
  elem_t ma [9];
  elem_t mb [9];
  elem_t r  [9];

  logic            sel_vld_q;
  logic [T_W-1:0]  t_d, t_q;
  side_t           side_d, side_q;
  logic [RT_W-1:0] sq_root;
  side_t           sq_side;
  logic [NUM_W-1:0] dv_quo;
  logic [RT_W-1:0]  dv_den;
  side_t            dv_side;
  logic [NUM_W-1:0] inv;

  logic                    sc_vld_q;
  logic signed [PW-2:0]    sc_p_q [3];
  logic [RT_W-1:0]         sc_hr_q;
  big_e                    sc_big_q;

  logic  out_vld_q;
  comp_t rel_w_q, rel_x_q, rel_y_q, rel_z_q;
  comp_t q0, q1, q2, hr;

  assign en      = !(out_vld_q && stall_i);
  assign stall_o = !en;

  rqrm_quat_mat u_mat_a (
    .clk_i, .rst_ni, .en_i(en), .vld_i(valid_i),
    .w_i(a_w_i), .x_i(a_x_i), .y_i(a_y_i), .z_i(a_z_i),
    .vld_o(ma_vld), .m_o(ma)
  );

  rqrm_quat_mat u_mat_b (
    .clk_i, .rst_ni, .en_i(en), .vld_i(valid_i),
    .w_i(b_w_i), .x_i(b_x_i), .y_i(b_y_i), .z_i(b_z_i),
    .vld_o(mb_vld), .m_o(mb)
  );

  rqrm_mat_mul u_mat_mul (
    .clk_i, .rst_ni, .en_i(en), .vld_i(ma_vld && mb_vld),
    .ma_i(ma), .mb_i(mb), .vld_o(r_vld), .r_o(r)
  );

  always_comb begin
    logic signed [EW+1:0] trace;
    logic signed [EW+1:0] tt;
    elem_t d_w, d_x, d_y, s_xy, s_xz, s_yz;
    trace = (EW+2)'(r[0]) + (EW+2)'(r[4]) + (EW+2)'(r[8]);
    d_w   = r[7] - r[5];
    d_x   = r[2] - r[6];
    d_y   = r[3] - r[1];
    s_xy  = r[1] + r[3];
    s_xz  = r[2] + r[6];
    s_yz  = r[5] + r[7];
    if (trace > 0) begin
      side_d.big = BIG_W;
      tt = trace + (EW+2)'(ONE);
      side_d.d0 = d_w;
      side_d.d1 = d_x;
      side_d.d2 = d_y;
    end else if (r[0] > r[4] && r[0] > r[8]) begin
      side_d.big = BIG_X;
      tt = (EW+2)'(ONE) + (EW+2)'(r[0]) - (EW+2)'(r[4]) - (EW+2)'(r[8]);
      side_d.d0 = d_w;
      side_d.d1 = s_xy;
      side_d.d2 = s_xz;
    end else if (r[4] > r[8]) begin
      side_d.big = BIG_Y;
      tt = (EW+2)'(ONE) + (EW+2)'(r[4]) - (EW+2)'(r[0]) - (EW+2)'(r[8]);
      side_d.d0 = d_x;
      side_d.d1 = s_xy;
      side_d.d2 = s_yz;
    end else begin
      side_d.big = BIG_Z;
      tt = (EW+2)'(ONE) + (EW+2)'(r[8]) - (EW+2)'(r[0]) - (EW+2)'(r[4]);
      side_d.d0 = d_y;
      side_d.d1 = s_xz;
      side_d.d2 = s_yz;
    end
    t_d = (tt < 0) ? '0 : T_W'(tt);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_vld_q <= 1'b0;
      sc_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      sel_vld_q <= r_vld;
      sc_vld_q  <= dv_vld;
      out_vld_q <= sc_vld_q;
    end
  end

  rqrm_sqrt u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .vld_i(sel_vld_q), .t_i(t_q), .side_i(side_q),
    .vld_o(sq_vld), .root_o(sq_root), .side_o(sq_side)
  );

  rqrm_div u_div (
    .clk_i, .rst_ni, .en_i(en), .vld_i(sq_vld), .den_i(sq_root), .side_i(sq_side),
    .vld_o(dv_vld), .quo_o(dv_quo), .den_o(dv_den), .side_o(dv_side)
  );

  assign inv = (dv_den == '0) ? '0 : dv_quo;

  always_comb begin
    q0 = sat_out(rnd_sh(PW'(sc_p_q[0])));
    q1 = sat_out(rnd_sh(PW'(sc_p_q[1])));
    q2 = sat_out(rnd_sh(PW'(sc_p_q[2])));
    hr = sat_out(PW'(sc_hr_q));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t_q       <= t_d;
      side_q    <= side_d;
      sc_p_q[0] <= dv_side.d0 * $signed({1'b0, inv});
      sc_p_q[1] <= dv_side.d1 * $signed({1'b0, inv});
      sc_p_q[2] <= dv_side.d2 * $signed({1'b0, inv});
      sc_hr_q   <= RT_W'(({1'b0, dv_den} + 1'b1) >> 1);
      sc_big_q  <= dv_side.big;
      case (sc_big_q)
        BIG_W: begin
          rel_w_q <= hr; rel_x_q <= q0; rel_y_q <= q1; rel_z_q <= q2;
        end
        BIG_X: begin
          rel_w_q <= q0; rel_x_q <= hr; rel_y_q <= q1; rel_z_q <= q2;
        end
        BIG_Y: begin
          rel_w_q <= q0; rel_x_q <= q1; rel_y_q <= hr; rel_z_q <= q2;
        end
        default: begin
          rel_w_q <= q0; rel_x_q <= q1; rel_y_q <= q2; rel_z_q <= hr;
        end
      endcase
    end
  end

  assign valid_o = out_vld_q;
  assign rel_w_o = rel_w_q;
  assign rel_x_o = rel_x_q;
  assign rel_y_o = rel_y_q;
  assign rel_z_o = rel_z_q;

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (rel_w_o <= CW'(OUT_MAX) && rel_w_o >= CW'(OUT_MIN) &&
                 rel_x_o <= CW'(OUT_MAX) && rel_x_o >= CW'(OUT_MIN) &&
                 rel_y_o <= CW'(OUT_MAX) && rel_y_o >= CW'(OUT_MIN) &&
                 rel_z_o <= CW'(OUT_MAX) && rel_z_o >= CW'(OUT_MIN)))
    else $error("result outside saturation range");

  a_hold_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!en && sc_vld_q) |=> (sc_vld_q && $stable(sc_hr_q) && $stable(sc_big_q)))
    else $error("scale stage moved under stall");

  a_zero_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && dv_vld && dv_den == '0) |=>
      (sc_p_q[0] == '0 && sc_p_q[1] == '0 && sc_p_q[2] == '0 && sc_hr_q == '0))
    else $error("zero root did not give zero terms");

endmodule
`default_nettype wire

>>> sim/relative_quaternion_via_rotation_matrix_core_test.sv
// ----------------------------------------------------------------------------
// relative_quaternion_via_rotation_matrix_core_test
// Drives quaternion pairs into the core and compares every relative
// quaternion with a fixed-point prediction of A^T*B converted back by
// Shepperd's method. Directed rows first, then random unit and raw pairs
// under two idling profiles, then none with one long output hold-off.
// ----------------------------------------------------------------------------
module relative_quaternion_via_rotation_matrix_core_test import rqrm_pkg::*;;

  localparam int LATENCY   = 18;
  localparam int WDOG_MAX  = 20000;
  localparam int N_RANDOM  = 1830;
  localparam int HOLD_LEN  = 200;

  typedef struct {
    comp_t aw, ax, ay, az, bw, bx, by, bz;
  } pair_t;

  typedef struct {
    comp_t w, x, y, z;
  } quat_t;

  typedef struct {
    pair_t p;
    logic  has_exp;
    quat_t q;
  } row_t;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  valid_i = 1'b0;
  logic  stall_o;
  comp_t a_w_i = '0, a_x_i = '0, a_y_i = '0, a_z_i = '0;
  comp_t b_w_i = '0, b_x_i = '0, b_y_i = '0, b_z_i = '0;
  logic  valid_o;
  logic  stall_i = 1'b0;
  comp_t rel_w_o, rel_x_o, rel_y_o, rel_z_o;

  quat_t pending_rel[$];
  int    n_fail = 0;
  int    idle_cycles = 0;
  int    send_idle_pct = 0;
  int    recv_idle_pct = 0;
  logic  hold_req = 1'b0;
  logic  hold_on = 1'b0;

  always #4 clk_i = ~clk_i;

  relative_quaternion_via_rotation_matrix_core i_dut (
    .clk_i, .rst_ni, .valid_i, .stall_o,
    .a_w_i, .a_x_i, .a_y_i, .a_z_i, .b_w_i, .b_x_i, .b_y_i, .b_z_i,
    .valid_o, .stall_i, .rel_w_o, .rel_x_o, .rel_y_o, .rel_z_o
  );

  function automatic longint round_shift(longint v);
    longint h;
    h = longint'(1) << (FRAC_BITS - 1);
    if (v >= 0) return (v + h) >>> FRAC_BITS;
    return -((-v + h) >>> FRAC_BITS);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint int_sqrt(longint n);
    longint res, b;
    res = 0;
    b = longint'(1) << 62;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >>> 1) + b;
      end else begin
        res = res >>> 1;
      end
      b = b >>> 2;
    end
    return res;
  endfunction

  function automatic longint scale_inv(longint d, longint inv);
    longint lim, mag, p;
    lim = 64'h7fff_ffff_ffff_ffff;
    mag = d < 0 ? -d : d;
    if (mag != 0 && inv > lim / mag) p = lim;
    else p = mag * inv;
    if (p > lim - (longint'(1) << (FRAC_BITS - 1)))
      p = lim - (longint'(1) << (FRAC_BITS - 1));
    return round_shift(d < 0 ? -p : p);
  endfunction

  function automatic void rot_matrix(longint w, longint x, longint y, longint z,
                                     output longint m[3][3]);
    longint one, two;
    one = longint'(ONE);
    two = longint'(TWO);
    m[0][0] = clip(one - round_shift(2 * (y * y + z * z)), -two, two);
    m[0][1] = clip(round_shift(2 * (x * y - w * z)), -two, two);
    m[0][2] = clip(round_shift(2 * (x * z + w * y)), -two, two);
    m[1][0] = clip(round_shift(2 * (x * y + w * z)), -two, two);
    m[1][1] = clip(one - round_shift(2 * (x * x + z * z)), -two, two);
    m[1][2] = clip(round_shift(2 * (y * z - w * x)), -two, two);
    m[2][0] = clip(round_shift(2 * (x * z - w * y)), -two, two);
    m[2][1] = clip(round_shift(2 * (y * z + w * x)), -two, two);
    m[2][2] = clip(one - round_shift(2 * (x * x + y * y)), -two, two);
  endfunction

  function automatic comp_t to_out(longint v);
    return comp_t'(clip(v, OUT_MIN, OUT_MAX));
  endfunction

  function automatic quat_t relative_quat(pair_t p);
    longint ma[3][3], mb[3][3], r[3][3];
    longint acc, tr, t, root, inv, hr, one;
    longint q[4];
    big_e   big;
    quat_t  res;
    one = longint'(ONE);
    rot_matrix(p.aw, p.ax, p.ay, p.az, ma);
    rot_matrix(p.bw, p.bx, p.by, p.bz, mb);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += round_shift(ma[k][i] * mb[k][j]);
        r[i][j] = clip(acc, -longint'(TWO), longint'(TWO));
      end
    end
    tr = r[0][0] + r[1][1] + r[2][2];
    if (tr > 0) begin
      big = BIG_W;
      t = tr + one;
    end else if (r[0][0] > r[1][1] && r[0][0] > r[2][2]) begin
      big = BIG_X;
      t = one + r[0][0] - r[1][1] - r[2][2];
    end else if (r[1][1] > r[2][2]) begin
      big = BIG_Y;
      t = one + r[1][1] - r[0][0] - r[2][2];
    end else begin
      big = BIG_Z;
      t = one + r[2][2] - r[0][0] - r[1][1];
    end
    if (t < 0) t = 0;
    root = int_sqrt(t << FRAC_BITS);
    inv = root == 0 ? 0 : ((longint'(1) << (2 * FRAC_BITS - 1)) + (root >>> 1)) / root;
    hr = (root + 1) >>> 1;
    case (big)
      BIG_W: begin
        q[0] = hr;
        q[1] = scale_inv(r[2][1] - r[1][2], inv);
        q[2] = scale_inv(r[0][2] - r[2][0], inv);
        q[3] = scale_inv(r[1][0] - r[0][1], inv);
      end
      BIG_X: begin
        q[0] = scale_inv(r[2][1] - r[1][2], inv);
        q[1] = hr;
        q[2] = scale_inv(r[0][1] + r[1][0], inv);
        q[3] = scale_inv(r[0][2] + r[2][0], inv);
      end
      BIG_Y: begin
        q[0] = scale_inv(r[0][2] - r[2][0], inv);
        q[1] = scale_inv(r[0][1] + r[1][0], inv);
        q[2] = hr;
        q[3] = scale_inv(r[1][2] + r[2][1], inv);
      end
      default: begin
        q[0] = scale_inv(r[1][0] - r[0][1], inv);
        q[1] = scale_inv(r[0][2] + r[2][0], inv);
        q[2] = scale_inv(r[1][2] + r[2][1], inv);
        q[3] = hr;
      end
    endcase
    res.w = to_out(q[0]);
    res.x = to_out(q[1]);
    res.y = to_out(q[2]);
    res.z = to_out(q[3]);
    return res;
  endfunction

  function automatic pair_t mk(int aw, int ax, int ay, int az, int bw, int bx, int by, int bz);
    pair_t p;
    p.aw = comp_t'(aw); p.ax = comp_t'(ax); p.ay = comp_t'(ay); p.az = comp_t'(az);
    p.bw = comp_t'(bw); p.bx = comp_t'(bx); p.by = comp_t'(by); p.bz = comp_t'(bz);
    return p;
  endfunction

  function automatic quat_t mq(int w, int x, int y, int z);
    quat_t q;
    q.w = comp_t'(w); q.x = comp_t'(x); q.y = comp_t'(y); q.z = comp_t'(z);
    return q;
  endfunction

  function automatic comp_t rand_comp();
    return comp_t'($urandom_range(2 * ONE) - ONE);
  endfunction

  // Roughly unit quaternion: random direction, normalized in real arithmetic.
  function automatic pair_t rand_unit_pair();
    real v[8], na, nb;
    pair_t p;
    for (int i = 0; i < 8; i++) v[i] = real'($urandom_range(2000)) - 1000.0;
    na = $sqrt(v[0]*v[0] + v[1]*v[1] + v[2]*v[2] + v[3]*v[3]) + 1.0e-9;
    nb = $sqrt(v[4]*v[4] + v[5]*v[5] + v[6]*v[6] + v[7]*v[7]) + 1.0e-9;
    p.aw = comp_t'($rtoi(v[0] / na * ONE)); p.ax = comp_t'($rtoi(v[1] / na * ONE));
    p.ay = comp_t'($rtoi(v[2] / na * ONE)); p.az = comp_t'($rtoi(v[3] / na * ONE));
    p.bw = comp_t'($rtoi(v[4] / nb * ONE)); p.bx = comp_t'($rtoi(v[5] / nb * ONE));
    p.by = comp_t'($rtoi(v[6] / nb * ONE)); p.bz = comp_t'($rtoi(v[7] / nb * ONE));
    return p;
  endfunction

  function automatic pair_t rand_pair();
    int sel;
    pair_t p;
    sel = $urandom_range(99);
    if (sel < 70) return rand_unit_pair();
    if (sel < 85) begin
      p.aw = rand_comp(); p.ax = rand_comp(); p.ay = rand_comp(); p.az = rand_comp();
      p.bw = rand_comp(); p.bx = rand_comp(); p.by = rand_comp(); p.bz = rand_comp();
      return p;
    end
    p.aw = comp_t'($urandom); p.ax = comp_t'($urandom); p.ay = comp_t'($urandom);
    p.az = comp_t'($urandom); p.bw = comp_t'($urandom); p.bx = comp_t'($urandom);
    p.by = comp_t'($urandom); p.bz = comp_t'($urandom);
    return p;
  endfunction

  task automatic send_request(pair_t p, quat_t exp_q);
    while ($urandom_range(99) < send_idle_pct) begin
      valid_i <= 1'b0;
      @(negedge clk_i);
    end
    valid_i <= 1'b1;
    a_w_i <= p.aw; a_x_i <= p.ax; a_y_i <= p.ay; a_z_i <= p.az;
    b_w_i <= p.bw; b_x_i <= p.bx; b_y_i <= p.by; b_z_i <= p.bz;
    do @(posedge clk_i); while (stall_o);
    pending_rel.push_back(exp_q);
    @(negedge clk_i);
  endtask

  task automatic check_field(string name, comp_t exp_v, comp_t act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      n_fail++;
    end
  endtask

  always @(negedge clk_i) begin
    if (hold_req && !hold_on) begin
      hold_on <= 1'b1;
      stall_i <= 1'b1;
      for (int i = 0; i < HOLD_LEN; i++) @(negedge clk_i);
      hold_on <= 1'b0;
      hold_req <= 1'b0;
    end else if (!hold_on) begin
      stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    quat_t e;
    if (rst_ni) begin
      if ((valid_i && !stall_o) || (valid_o && !stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (valid_o && !stall_i) begin
        if (pending_rel.size() == 0) begin
          $error("unexpected result %0d %0d %0d %0d", rel_w_o, rel_x_o, rel_y_o, rel_z_o);
          n_fail++;
        end else begin
          e = pending_rel.pop_front();
          check_field("rel_w", e.w, rel_w_o);
          check_field("rel_x", e.x, rel_x_o);
          check_field("rel_y", e.y, rel_y_o);
          check_field("rel_z", e.z, rel_z_o);
        end
      end
      if (idle_cycles >= WDOG_MAX) begin
        $display("relative_quaternion_via_rotation_matrix_core test failed");
        $finish;
      end
    end
  end

  initial begin
    row_t rows[$];
    row_t rw;
    pair_t p;
    int m;
    m = 16384;
    rw.has_exp = 1'b1;
    rw.p = mk(m, 0, 0, 0, m, 0, 0, 0);       rw.q = mq(m, 0, 0, 0);     rows.push_back(rw);
    rw.p = mk(-m, 0, 0, 0, m, 0, 0, 0);      rw.q = mq(m, 0, 0, 0);     rows.push_back(rw);
    rw.p = mk(0, 0, 0, 0, 0, 0, 0, 0);       rw.q = mq(m, 0, 0, 0);     rows.push_back(rw);
    rw.has_exp = 1'b0;
    rw.p = mk(m, 0, 0, 0, 0, m, 0, 0);       rows.push_back(rw);
    rw.p = mk(m, 0, 0, 0, 0, 0, m, 0);       rows.push_back(rw);
    rw.p = mk(m, 0, 0, 0, 0, 0, 0, m);       rows.push_back(rw);
    rw.p = mk(0, m, 0, 0, 0, 0, m, 0);       rows.push_back(rw);
    rw.p = mk(0, 0, 0, m, 0, m, 0, 0);       rows.push_back(rw);
    rw.p = mk(0, m, 0, 0, m, 0, 0, 0);       rows.push_back(rw);
    rw.p = mk(11585, 11585, 0, 0, 11585, 0, 11585, 0); rows.push_back(rw);
    rw.p = mk(8192, 8192, 8192, 8192, m, 0, 0, 0);     rows.push_back(rw);
    rw.p = mk(0, 11585, 11585, 0, 0, 0, 0, m);         rows.push_back(rw);
    rw.p = mk(-m, -m, -m, -m, m, m, m, m);             rows.push_back(rw);
    rw.p = mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767); rows.push_back(rw);
    rw.p = mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
    rows.push_back(rw);
    rw.p = mk(32767, -32768, 32767, -32768, -32768, 32767, -32768, 32767); rows.push_back(rw);
    rw.p = mk(-1, -1, -1, -1, -1, -1, -1, -1);          rows.push_back(rw);
    rw.p = mk(0, 0, 0, 0, 0, m, m, 0);                  rows.push_back(rw);
    rw.p = mk(100, 0, 0, 0, 0, 0, 0, 100);              rows.push_back(rw);

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].has_exp) begin
        send_request(rows[i].p, rows[i].q);
      end else begin
        send_request(rows[i].p, relative_quat(rows[i].p));
      end
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 3) begin
        send_idle_pct = 63; recv_idle_pct = 36;
      end else if (i == 2 * N_RANDOM / 3) begin
        send_idle_pct = 0; recv_idle_pct = 0;
        hold_req <= 1'b1;
      end else if (i == 0) begin
        send_idle_pct = 36; recv_idle_pct = 63;
      end
      p = rand_pair();
      send_request(p, relative_quat(p));
    end
    valid_i <= 1'b0;

    while (pending_rel.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
    if (n_fail == 0) begin
      $display("relative_quaternion_via_rotation_matrix_core test passed");
    end else begin
      $display("relative_quaternion_via_rotation_matrix_core test failed");
    end
    $finish;
  end

endmodule
